// ----- rtl/fomm_pkg.sv -----
// Shared types, widths and constants of the field-oriented mecanum mixer.
// Holds the arctangent table used by the rotation cells.
// No dependencies.
package fomm_pkg;

   // Field and datapath widths
   localparam int VEL_W     = 16;               // Q4.11 velocity fields
   localparam int ANG_W     = 16;               // Q3.12 heading angle
   localparam int LEVER_W   = 16;               // Q0.16 wheel lever
   localparam int WHEEL_W   = 18;               // saturated wheel speed
   localparam int WRAP_W    = ANG_W + 1;        // negated angle, exact for -min
   localparam int XY_W      = 27;               // rotation x/y, Q.24
   localparam int Z_W       = 28;               // residual angle, Q.24
   localparam int PROD_W    = XY_W + VEL_W;     // one cos/sin product
   localparam int PSUM_W    = PROD_W + 1;       // sum of two products
   localparam int ROT_W     = 18;               // rotated velocity, Q6.11
   localparam int YAW_W     = VEL_W + LEVER_W + 1;
   localparam int W_W       = VEL_W + 1;        // yaw term after rounding
   localparam int MIX_W     = 20;               // wheel sum before clamping
   localparam int FRAC_SH   = 24;               // Q.35 -> Q.11

   // Stage count limits
   localparam int MAX_STAGES          = 24;
   localparam int ROTATION_STAGES_DEF = 16;

   // Angle constants
   localparam logic signed [WRAP_W-1:0] PI_Q12       = 17'sd12868;
   localparam logic signed [WRAP_W-1:0] TWO_PI_Q12   = 17'sd25736;
   // Largest Q3.12 angle whose Q.24 value is still within +-pi/2
   localparam logic signed [WRAP_W-1:0] HALF_PI_LIM  = 17'sd6433;
   localparam logic signed [Z_W-1:0]    PI_Q24       = 28'sd52707179;
   localparam logic signed [XY_W-1:0]   GAIN_Q24     = 27'sd10188014;
   localparam logic signed [PSUM_W-1:0] ROUND_HALF   = PSUM_W'(64'sd1 <<< (FRAC_SH - 1));
   localparam logic signed [YAW_W-1:0]  YAW_HALF     = YAW_W'(64'sd1 <<< (LEVER_W - 1));

   // Output limits
   localparam logic signed [MIX_W-1:0] OUT_MAX = 20'sd131071;
   localparam logic signed [MIX_W-1:0] OUT_MIN = -20'sd131072;

   // Command payload carried alongside the rotation
   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] yaw_rate;
      logic                    spin_mode;
      logic                    flip;       // angle folded by pi, negate cos/sin
   } fomm_cmd_type;

   // Rotation state handed from cell to cell
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } fomm_rot_type;

   // Result bundle
   typedef struct packed {
      logic signed [WHEEL_W-1:0] wheel_a_speed;
      logic signed [WHEEL_W-1:0] wheel_b_speed;
      logic signed [WHEEL_W-1:0] wheel_c_speed;
      logic signed [WHEEL_W-1:0] wheel_d_speed;
      logic                      clipped;
   } fomm_rsp_type;

   // atan(2^-i) in Q.24
   function automatic logic signed [Z_W-1:0] atan_q24(input int unsigned idx);
      case (idx)
         0: return 28'sd13176795;
         1: return 28'sd7778716;
         2: return 28'sd4110060;
         3: return 28'sd2086331;
         4: return 28'sd1047214;
         5: return 28'sd524117;
         6: return 28'sd262123;
         7: return 28'sd131069;
         8: return 28'sd65536;
         9: return 28'sd32768;
         10: return 28'sd16384;
         11: return 28'sd8192;
         12: return 28'sd4096;
         13: return 28'sd2048;
         14: return 28'sd1024;
         15: return 28'sd512;
         16: return 28'sd256;
         17: return 28'sd128;
         18: return 28'sd64;
         19: return 28'sd32;
         20: return 28'sd16;
         21: return 28'sd8;
         22: return 28'sd4;
         23: return 28'sd2;
         default: return '0;
      endcase
   endfunction

endpackage

// ----- rtl/fomm_prep.sv -----
// Input stage: negates and wraps the heading, folds it into +-pi/2 and
// seeds the rotation state. Depends on fomm_pkg.
module fomm_prep (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [15:0]           vel_x,
   input  logic signed [15:0]           vel_y,
   input  logic signed [15:0]           yaw_rate,
   input  logic signed [15:0]           heading_angle,
   input  logic                         spin_mode,
   output logic                         valid_o,
   output fomm_pkg::fomm_rot_type       rot_o,
   output fomm_pkg::fomm_cmd_type       cmd_o
);
   import fomm_pkg::*;

   logic signed [WRAP_W-1:0] neg_ang;
   logic signed [WRAP_W-1:0] wrap_ang;
   logic signed [Z_W-1:0]    z_scaled;
   logic                     valid_ff, valid_in;
   fomm_rot_type             rot_ff, rot_in;
   fomm_cmd_type             cmd_ff, cmd_in;

   // Negate at 17 bits, then one wrap step brings it into [-pi, pi]
   always_comb begin
      neg_ang = WRAP_W'(0) - WRAP_W'(heading_angle);
      if (neg_ang > PI_Q12) begin
         wrap_ang = neg_ang - TWO_PI_Q12;
      end else if (neg_ang < -PI_Q12) begin
         wrap_ang = neg_ang + TWO_PI_Q12;
      end else begin
         wrap_ang = neg_ang;
      end
      z_scaled = Z_W'(wrap_ang) <<< 12;
   end

   // Fold beyond +-pi/2 and seed the rotation
   always_comb begin
      valid_in       = accept;
      rot_in.x       = GAIN_Q24;
      rot_in.y       = '0;
      cmd_in.vel_x     = vel_x;
      cmd_in.vel_y     = vel_y;
      cmd_in.yaw_rate  = yaw_rate;
      cmd_in.spin_mode = spin_mode;
      if (wrap_ang > HALF_PI_LIM) begin
         rot_in.z    = z_scaled - PI_Q24;
         cmd_in.flip = 1'b1;
      end else if (wrap_ang < -HALF_PI_LIM) begin
         rot_in.z    = z_scaled + PI_Q24;
         cmd_in.flip = 1'b1;
      end else begin
         rot_in.z    = z_scaled;
         cmd_in.flip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in;
      cmd_ff <= cmd_in;
   end

   assign valid_o = valid_ff;
   assign rot_o   = rot_ff;
   assign cmd_o   = cmd_ff;

endmodule

// ----- rtl/fomm_cell.sv -----
// One rotation-mode CORDIC cell: a fixed shift and arctangent step,
// registered, with the request payload carried along. Depends on fomm_pkg.
module fomm_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_i,
   input  fomm_pkg::fomm_rot_type  rot_i,
   input  fomm_pkg::fomm_cmd_type  cmd_i,
   output logic                    valid_o,
   output fomm_pkg::fomm_rot_type  rot_o,
   output fomm_pkg::fomm_cmd_type  cmd_o
);
   import fomm_pkg::*;

   localparam logic signed [Z_W-1:0] ANGLE = atan_q24(STAGE);

   logic signed [XY_W-1:0] dx, dy;
   logic                   valid_ff, valid_in;
   fomm_rot_type           rot_ff, rot_in;
   fomm_cmd_type           cmd_ff;

   // Micro-rotation toward zero residual angle; shifts floor
   always_comb begin
      dx = rot_i.y >>> STAGE;
      dy = rot_i.x >>> STAGE;
      if (!rot_i.z[Z_W-1]) begin
         rot_in.x = rot_i.x - dx;
         rot_in.y = rot_i.y + dy;
         rot_in.z = rot_i.z - ANGLE;
      end else begin
         rot_in.x = rot_i.x + dx;
         rot_in.y = rot_i.y - dy;
         rot_in.z = rot_i.z + ANGLE;
      end
      valid_in = valid_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in;
      cmd_ff <= cmd_i;
   end

   assign valid_o = valid_ff;
   assign rot_o   = rot_ff;
   assign cmd_o   = cmd_ff;

endmodule

// ----- rtl/fomm_mix.sv -----
// Back end: applies cos/sin to the velocity vector, scales the yaw rate by
// the wheel lever and mixes four saturated wheel speeds. Depends on fomm_pkg.
module fomm_mix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        valid_i,
   input  fomm_pkg::fomm_rot_type      rot_i,
   input  fomm_pkg::fomm_cmd_type      cmd_i,
   input  logic [15:0]                 wheel_lever,
   output logic                        valid_o,
   output fomm_pkg::fomm_rsp_type      rsp_o
);
   import fomm_pkg::*;

   // Clamp to the 18-bit output range, reporting saturation
   function automatic logic signed [WHEEL_W-1:0] sat(
      input logic signed [MIX_W-1:0] v,
      output logic                   hit
   );
      hit = 1'b1;
      if (v > OUT_MAX) begin
         return WHEEL_W'(OUT_MAX);
      end else if (v < OUT_MIN) begin
         return WHEEL_W'(OUT_MIN);
      end
      hit = 1'b0;
      return WHEEL_W'(v);
   endfunction

   // Product stage
   logic                     p_valid_ff;
   logic signed [PROD_W-1:0] p_cx_ff, p_cy_ff, p_sx_ff, p_sy_ff;
   logic signed [PROD_W-1:0] p_cx_in, p_cy_in, p_sx_in, p_sy_in;
   logic signed [YAW_W-1:0]  p_yaw_ff, p_yaw_in;
   fomm_cmd_type             p_cmd_ff;

   // Rounding stage
   logic                     r_valid_ff;
   logic signed [PSUM_W-1:0] sum_x, sum_y, rnd_x, rnd_y;
   logic signed [YAW_W-1:0]  rnd_yaw;
   logic signed [ROT_W-1:0]  r_vx_ff, r_vy_ff, r_vx_in, r_vy_in;
   logic signed [W_W-1:0]    r_w_ff, r_w_in;

   // Output stage
   logic                     o_valid_ff;
   logic signed [MIX_W-1:0]  mix_a, mix_b, mix_c, mix_d, diff, plus;
   logic                     hit_a, hit_b, hit_c, hit_d;
   fomm_rsp_type             o_rsp_ff, o_rsp_in;

   // Four cos/sin products and the yaw lever product
   always_comb begin
      p_cx_in  = PROD_W'(rot_i.x) * PROD_W'(cmd_i.vel_x);
      p_sy_in  = PROD_W'(rot_i.y) * PROD_W'(cmd_i.vel_y);
      p_cy_in  = PROD_W'(rot_i.x) * PROD_W'(cmd_i.vel_y);
      p_sx_in  = PROD_W'(rot_i.y) * PROD_W'(cmd_i.vel_x);
      p_yaw_in = YAW_W'(cmd_i.yaw_rate) * signed'({1'b0, wheel_lever});
   end

   always_ff @(posedge clock) begin
      p_cx_ff  <= p_cx_in;
      p_cy_ff  <= p_cy_in;
      p_sx_ff  <= p_sx_in;
      p_sy_ff  <= p_sy_in;
      p_yaw_ff <= p_yaw_in;
      p_cmd_ff <= cmd_i;
   end

   // Sum, undo the pi fold, round half up to Q6.11; bypass outside spin mode
   always_comb begin
      sum_x = PSUM_W'(p_cx_ff) + PSUM_W'(p_sy_ff);
      sum_y = PSUM_W'(p_cy_ff) - PSUM_W'(p_sx_ff);
      if (p_cmd_ff.flip) begin
         sum_x = -sum_x;
         sum_y = -sum_y;
      end
      rnd_x   = sum_x + ROUND_HALF;
      rnd_y   = sum_y + ROUND_HALF;
      rnd_yaw = p_yaw_ff + YAW_HALF;
      r_w_in  = rnd_yaw[YAW_W-1:LEVER_W];
      if (p_cmd_ff.spin_mode) begin
         r_vx_in = rnd_x[FRAC_SH+ROT_W-1:FRAC_SH];
         r_vy_in = rnd_y[FRAC_SH+ROT_W-1:FRAC_SH];
      end else begin
         r_vx_in = ROT_W'(p_cmd_ff.vel_x);
         r_vy_in = ROT_W'(p_cmd_ff.vel_y);
      end
   end

   always_ff @(posedge clock) begin
      r_vx_ff <= r_vx_in;
      r_vy_ff <= r_vy_in;
      r_w_ff  <= r_w_in;
   end

   // Mecanum mixing with saturation
   always_comb begin
      diff  = MIX_W'(r_vy_ff) - MIX_W'(r_vx_ff);
      plus  = MIX_W'(r_vy_ff) + MIX_W'(r_vx_ff);
      mix_a = diff - MIX_W'(r_w_ff);
      mix_b = plus - MIX_W'(r_w_ff);
      mix_c = diff + MIX_W'(r_w_ff);
      mix_d = plus + MIX_W'(r_w_ff);
      o_rsp_in.wheel_a_speed = sat(mix_a, hit_a);
      o_rsp_in.wheel_b_speed = sat(mix_b, hit_b);
      o_rsp_in.wheel_c_speed = sat(mix_c, hit_c);
      o_rsp_in.wheel_d_speed = sat(mix_d, hit_d);
      o_rsp_in.clipped       = hit_a | hit_b | hit_c | hit_d;
   end

   always_ff @(posedge clock) begin
      o_rsp_ff <= o_rsp_in;
   end

   // Valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= valid_i;
         r_valid_ff <= p_valid_ff;
         o_valid_ff <= r_valid_ff;
      end
   end

   assign valid_o = o_valid_ff;
   assign rsp_o   = o_rsp_ff;

endmodule

// ----- rtl/field_oriented_mecanum_mixer_core.sv -----
// Top level of the field-oriented mecanum mixer: input stage, a row of
// CORDIC cells and the mixing back end. Depends on fomm_pkg, fomm_prep,
// fomm_cell and fomm_mix.

// A request (vel_x, vel_y, yaw_rate, heading_angle, spin_mode) is taken on
// every clock edge where start is high; busy stays low, so one request per
// cycle is sustained. Each request gives exactly one result, shown on the
// rsp_ ports for one cycle with rsp_valid high, after passing the registers
// of the angle wrap, each CORDIC cell (ROTATION_STAGES, capped at 24), the
// products, the rounding and the mixing, in that order.
// Results come in request order and cannot be held off; the receiver must
// take each one in the cycle it appears. wheel_lever is written through
// csr_wr_en/csr_wr_data and should only change while no request is in flight.
module field_oriented_mecanum_mixer_core #(
   parameter int ROTATION_STAGES = fomm_pkg::ROTATION_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_vel_x,
   input  logic [15:0] req_vel_y,
   input  logic [15:0] req_yaw_rate,
   input  logic [15:0] req_heading_angle,
   input  logic        req_spin_mode,
   // result channel
   output logic        rsp_valid,
   output logic [17:0] rsp_wheel_a_speed,
   output logic [17:0] rsp_wheel_b_speed,
   output logic [17:0] rsp_wheel_c_speed,
   output logic [17:0] rsp_wheel_d_speed,
   output logic        rsp_clipped,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import fomm_pkg::*;

   localparam int NUM_CELLS = (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;
   localparam int LATENCY   = NUM_CELLS + 4;
   localparam logic [LEVER_W-1:0] LEVER_RESET = 16'd13107;

   logic                 accept;
   logic [LEVER_W-1:0]   wheel_lever_ff, wheel_lever_in;
   logic                 valid_chain [0:NUM_CELLS];
   fomm_rot_type         rot_chain   [0:NUM_CELLS];
   fomm_cmd_type         cmd_chain   [0:NUM_CELLS];
   fomm_rsp_type         rsp;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Wheel lever register
   always_comb begin
      wheel_lever_in = csr_wr_en ? csr_wr_data : wheel_lever_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_lever_ff <= LEVER_RESET;
      end else begin
         wheel_lever_ff <= wheel_lever_in;
      end
   end

   // Angle wrap and rotation seed
   fomm_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .vel_x         (signed'(req_vel_x)),
      .vel_y         (signed'(req_vel_y)),
      .yaw_rate      (signed'(req_yaw_rate)),
      .heading_angle (signed'(req_heading_angle)),
      .spin_mode     (req_spin_mode),
      .valid_o       (valid_chain[0]),
      .rot_o         (rot_chain[0]),
      .cmd_o         (cmd_chain[0])
   );

   // Row of CORDIC cells
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      fomm_cell #(
         .STAGE (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (valid_chain[k]),
         .rot_i   (rot_chain[k]),
         .cmd_i   (cmd_chain[k]),
         .valid_o (valid_chain[k+1]),
         .rot_o   (rot_chain[k+1]),
         .cmd_o   (cmd_chain[k+1])
      );
   end

   // Products, rounding and wheel mixing
   fomm_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .valid_i     (valid_chain[NUM_CELLS]),
      .rot_i       (rot_chain[NUM_CELLS]),
      .cmd_i       (cmd_chain[NUM_CELLS]),
      .wheel_lever (wheel_lever_ff),
      .valid_o     (rsp_valid),
      .rsp_o       (rsp)
   );

   assign rsp_wheel_a_speed = rsp.wheel_a_speed;
   assign rsp_wheel_b_speed = rsp.wheel_b_speed;
   assign rsp_wheel_c_speed = rsp.wheel_c_speed;
   assign rsp_wheel_d_speed = rsp.wheel_d_speed;
   assign rsp_clipped       = rsp.clipped;

`ifndef SYNTHESIS
   // Every request comes out after the fixed pipeline depth
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request did not produce a result after the pipeline depth");

   // Clip flag only when some wheel sits on a rail
   a_clip_rail : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         (signed'(rsp_wheel_a_speed) == WHEEL_W'(OUT_MAX)) ||
         (signed'(rsp_wheel_a_speed) == WHEEL_W'(OUT_MIN)) ||
         (signed'(rsp_wheel_b_speed) == WHEEL_W'(OUT_MAX)) ||
         (signed'(rsp_wheel_b_speed) == WHEEL_W'(OUT_MIN)) ||
         (signed'(rsp_wheel_c_speed) == WHEEL_W'(OUT_MAX)) ||
         (signed'(rsp_wheel_c_speed) == WHEEL_W'(OUT_MIN)) ||
         (signed'(rsp_wheel_d_speed) == WHEEL_W'(OUT_MAX)) ||
         (signed'(rsp_wheel_d_speed) == WHEEL_W'(OUT_MIN)))
      else $error("clip flag set with no wheel saturated");

   // Unsaturated mixing is balanced: a + d == b + c
   a_mix_balance : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_clipped |->
         (MIX_W'(signed'(rsp_wheel_a_speed)) + MIX_W'(signed'(rsp_wheel_d_speed))) ==
         (MIX_W'(signed'(rsp_wheel_b_speed)) + MIX_W'(signed'(rsp_wheel_c_speed))))
      else $error("wheel speeds not consistent with mecanum mixing");
`endif

endmodule
